// File: rtl/rpfa_pkg.sv
// shared types and constants for the page frame allocator
`default_nettype none

package rpfa_pkg;

	// payload widths fixed by the interface
	localparam int unsigned PAGE_NUM_W = 20;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned REQ_W      = 3;
	localparam int unsigned REF_OUT_W  = 16;
	localparam int unsigned FREE_CNT_W = 15;

	// default geometry
	localparam int unsigned NUM_PAGES_DEF = 16384;
	localparam int unsigned REF_WIDTH_DEF = 16;

	// request codes
	localparam logic [REQ_W-1:0] REQ_ALLOC     = 3'd0;
	localparam logic [REQ_W-1:0] REQ_FREE      = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INIT_FREE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_INC       = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DEC       = 3'd4;
	localparam logic [REQ_W-1:0] REQ_QUERY     = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_LIMIT = 2'd3;

	// control states, one-hot
	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

endpackage

`default_nettype wire

// File: rtl/rpfa_ram.sv
// simple dual port synchronous ram, one write port and one registered read port
`default_nettype none

module rpfa_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/refcounted_page_frame_allocator.sv
// top level of the page frame allocator: lifo free list plus per-page reference counts
// an item accepted in idle is captured with its ram reads, executed, then its result registered with done
// one item at a time: busy stays high through the read then write-back of the link and count rams
// reset: arst_n clears control state, then a clearing pass zeroes the count ram,
// one entry per cycle with busy high; config writes are taken during it
// the receiver cannot stall: each result shows for exactly one cycle with done
`default_nettype none

module refcounted_page_frame_allocator #(
	parameter int unsigned NUM_PAGES = rpfa_pkg::NUM_PAGES_DEF,
	parameter int unsigned REF_WIDTH = rpfa_pkg::REF_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration write channel
	input  wire logic                               cfg_valid,
	output      logic                               cfg_ready,
	input  wire logic [rpfa_pkg::PAGE_NUM_W-1:0]    cfg_data,
	// request side
	input  wire logic                               start,
	output      logic                               busy,
	input  wire logic [rpfa_pkg::REQ_W-1:0]         req_type,
	input  wire logic [rpfa_pkg::PAGE_NUM_W-1:0]    page_number,
	// result side
	output      logic                               done,
	output      logic [rpfa_pkg::STATUS_W-1:0]      status,
	output      logic [rpfa_pkg::PAGE_NUM_W-1:0]    result_page,
	output      logic [rpfa_pkg::REF_OUT_W-1:0]     ref_count,
	output      logic [rpfa_pkg::FREE_CNT_W-1:0]    free_page_count
);

	// page index and head pointer widths; the head holds page+1, zero when empty
	localparam int unsigned PAGE_W = $clog2(NUM_PAGES);
	localparam int unsigned PTR_W  = $clog2(NUM_PAGES + 1);
	localparam int unsigned PN_W   = rpfa_pkg::PAGE_NUM_W;

	localparam logic [PN_W:0]         PAGE_LIMIT = (PN_W + 1)'(NUM_PAGES);
	localparam logic [PAGE_W-1:0]     LAST_PAGE  = PAGE_W'(NUM_PAGES - 1);
	localparam logic [REF_WIDTH-1:0]  REF_MAX    = {REF_WIDTH{1'b1}};
	localparam logic [rpfa_pkg::FREE_CNT_W-1:0] FREE_MAX = {rpfa_pkg::FREE_CNT_W{1'b1}};

	rpfa_pkg::state_t state_q;

	logic [PN_W-1:0]   first_q;       // first usable page register
	logic [PTR_W-1:0]  head_q;        // list head, page+1
	logic [rpfa_pkg::FREE_CNT_W-1:0] free_q;
	logic [PAGE_W-1:0] clr_idx_q;     // clearing pass pointer

	// request captured at accept
	logic [rpfa_pkg::REQ_W-1:0] req_s1;
	logic [PN_W-1:0]            pg_s1;

	// result registers
	logic                            done_q;
	logic [rpfa_pkg::STATUS_W-1:0]   status_q;
	logic [PN_W-1:0]                 result_page_q;
	logic [rpfa_pkg::REF_OUT_W-1:0]  ref_count_q;

	// ram ports
	logic                 ref_we;
	logic [PAGE_W-1:0]    ref_waddr;
	logic [REF_WIDTH-1:0] ref_wdata;
	logic [REF_WIDTH-1:0] ref_rdata;
	logic                 link_we;
	logic [PTR_W-1:0]     link_rdata;

	logic accept;

	// execute stage results
	logic                          ex_ref_we;
	logic [PAGE_W-1:0]             ex_ref_addr;
	logic [REF_WIDTH-1:0]          ex_ref_val;
	logic                          ex_push;
	logic                          ex_pop;
	logic [rpfa_pkg::STATUS_W-1:0] ex_status;
	logic [PN_W-1:0]               ex_page;
	logic [REF_WIDTH-1:0]          ex_cnt;
	logic [REF_WIDTH+rpfa_pkg::REF_OUT_W-1:0] ex_cnt_ext;

	logic              in_range;
	logic [PAGE_W-1:0] pg_idx;
	logic [PAGE_W-1:0] top_idx;
	logic [REF_WIDTH-1:0] cur_cnt;
	logic [REF_WIDTH-1:0] dec_cnt;

	assign accept    = start && !busy;
	assign busy      = (state_q != rpfa_pkg::S_IDLE);
	assign cfg_ready = 1'b1;

	assign pg_idx  = pg_s1[PAGE_W-1:0];
	assign top_idx = PAGE_W'(head_q - PTR_W'(1));

	// valid page: first usable page up to the last page frame
	assign in_range = (pg_s1 >= first_q) && ({1'b0, pg_s1} < PAGE_LIMIT);

	// free and init free: init free drops the count to zero first
	assign cur_cnt = (req_s1 == rpfa_pkg::REQ_INIT_FREE) ? '0 : ref_rdata;
	assign dec_cnt = (cur_cnt != '0) ? cur_cnt - REF_WIDTH'(1) : '0;

	always_comb begin
		ex_ref_we   = 1'b0;
		ex_ref_addr = pg_idx;
		ex_ref_val  = ref_rdata;
		ex_push     = 1'b0;
		ex_pop      = 1'b0;
		ex_status   = rpfa_pkg::STAT_OK;
		ex_page     = pg_s1;
		ex_cnt      = '0;
		if (req_s1 == rpfa_pkg::REQ_ALLOC) begin
			if (head_q == '0) begin
				ex_status = rpfa_pkg::STAT_EMPTY;
				ex_page   = '0;
			end else begin
				// pop the top page and give it its first reference
				ex_pop      = 1'b1;
				ex_ref_we   = 1'b1;
				ex_ref_addr = top_idx;
				ex_ref_val  = REF_WIDTH'(1);
				ex_page     = PN_W'(top_idx);
				ex_cnt      = REF_WIDTH'(1);
			end
		end else if (req_s1 > rpfa_pkg::REQ_QUERY) begin
			// unknown request code: no effect
			ex_status = rpfa_pkg::STAT_OK;
		end else if (!in_range) begin
			ex_status = rpfa_pkg::STAT_RANGE;
		end else begin
			case (req_s1)
				rpfa_pkg::REQ_FREE, rpfa_pkg::REQ_INIT_FREE: begin
					ex_ref_we  = 1'b1;
					ex_ref_val = dec_cnt;
					ex_cnt     = dec_cnt;
					// a page whose count lands at zero goes on the list, even a second time
					ex_push    = (dec_cnt == '0);
				end
				rpfa_pkg::REQ_INC: begin
					if (ref_rdata == REF_MAX) begin
						ex_status = rpfa_pkg::STAT_LIMIT;
						ex_cnt    = ref_rdata;
					end else begin
						ex_ref_we  = 1'b1;
						ex_ref_val = ref_rdata + REF_WIDTH'(1);
						ex_cnt     = ref_rdata + REF_WIDTH'(1);
					end
				end
				rpfa_pkg::REQ_DEC: begin
					if (ref_rdata == '0) begin
						ex_status = rpfa_pkg::STAT_LIMIT;
					end else begin
						ex_ref_we  = 1'b1;
						ex_ref_val = ref_rdata - REF_WIDTH'(1);
						ex_cnt     = ref_rdata - REF_WIDTH'(1);
					end
				end
				default: begin
					// query
					ex_cnt = ref_rdata;
				end
			endcase
		end
	end

	// count out: low bits only, zero extended for narrow counts
	assign ex_cnt_ext = {{rpfa_pkg::REF_OUT_W{1'b0}}, ex_cnt};

	// count ram write port: clearing pass, else the execute cycle
	always_comb begin
		ref_we    = 1'b0;
		ref_waddr = ex_ref_addr;
		ref_wdata = ex_ref_val;
		if (state_q == rpfa_pkg::S_CLEAR) begin
			ref_we    = 1'b1;
			ref_waddr = clr_idx_q;
			ref_wdata = '0;
		end else if (state_q == rpfa_pkg::S_EXEC) begin
			ref_we = ex_ref_we;
		end
	end

	assign link_we = (state_q == rpfa_pkg::S_EXEC) && ex_push;

	// count table, read at accept with the incoming page
	rpfa_ram #(
		.DEPTH (NUM_PAGES),
		.WIDTH (REF_WIDTH)
	) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr (ref_waddr),
		.wdata (ref_wdata),
		.re    (accept),
		.raddr (page_number[PAGE_W-1:0]),
		.rdata (ref_rdata)
	);

	// link memory, read at accept below the current head; written on push
	rpfa_ram #(
		.DEPTH (NUM_PAGES),
		.WIDTH (PTR_W)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (pg_idx),
		.wdata (head_q),
		.re    (accept),
		.raddr (top_idx),
		.rdata (link_rdata)
	);

	// control state, head and free counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rpfa_pkg::S_CLEAR;
			clr_idx_q <= '0;
			head_q    <= '0;
			free_q    <= '0;
			first_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				first_q <= cfg_data;
			end
			case (state_q)
				rpfa_pkg::S_CLEAR: begin
					clr_idx_q <= clr_idx_q + PAGE_W'(1);
					if (clr_idx_q == LAST_PAGE) begin
						state_q <= rpfa_pkg::S_IDLE;
					end
				end
				rpfa_pkg::S_IDLE: begin
					if (start) begin
						state_q <= rpfa_pkg::S_EXEC;
					end
				end
				rpfa_pkg::S_EXEC: begin
					state_q <= rpfa_pkg::S_IDLE;
					done_q  <= 1'b1;
					if (ex_pop) begin
						head_q <= link_rdata;
						if (free_q != '0) begin
							free_q <= free_q - rpfa_pkg::FREE_CNT_W'(1);
						end
					end else if (ex_push) begin
						head_q <= PTR_W'({1'b0, pg_idx}) + PTR_W'(1);
						if (free_q != FREE_MAX) begin
							free_q <= free_q + rpfa_pkg::FREE_CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= rpfa_pkg::S_IDLE;
				end
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_type;
			pg_s1  <= page_number;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == rpfa_pkg::S_EXEC) begin
			status_q      <= ex_status;
			result_page_q <= ex_page;
			ref_count_q   <= ex_cnt_ext[rpfa_pkg::REF_OUT_W-1:0];
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign result_page     = result_page_q;
	assign ref_count       = ref_count_q;
	assign free_page_count = free_q;

endmodule

`default_nettype wire
